// ----- hw/rtl/slif_pkg.sv -----
// ----------------------------------------------------------------------------
// slif_pkg
// Shared codes and controller/datapath interface types for the sorted list.
// ----------------------------------------------------------------------------
package slif_pkg;

    // Action codes of an input word
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    // Status codes of a result word
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Field widths of the result word
    localparam int POS_W = 6;
    localparam int CNT_W = 7;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // latch input word, set up pointer and pending result
        logic rd;     // issue a memory read at the pointer
        logic shift;  // move the entry read one place up, step pointer down
        logic adv;    // step pointer up (find scan)
        logic put;    // write value at the pointer, bump the count
        logic found;  // record a match at the pointer
        logic full;   // record a dropped insert
        logic emit;   // load the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic act_find;  // latched action is find
        logic full;      // list holds CAPACITY entries
        logic ptr_zero;  // pointer is zero
        logic ptr_end;   // pointer equals the count
        logic ge;        // entry read is not smaller than the value
        logic match;     // entry read equals the value
        logic out_free;  // output register can take a word
    } t_stat;

endpackage

// ----- hw/rtl/slif_ctrl.sv -----
// ----------------------------------------------------------------------------
// slif_ctrl
// Sequencer for insert and find: scans the memory one entry at a time.
// ----------------------------------------------------------------------------
module slif_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slif_pkg::t_stat i_stat,
    output slif_pkg::t_cmd  o_cmd
);
    import slif_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.act_find) begin
                    if (i_stat.ptr_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_CMP;
                    end
                end else if (i_stat.full) begin
                    o_cmd.full = 1'b1;
                    n_state    = S_FIN;
                end else if (i_stat.ptr_zero) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.act_find) begin
                    if (i_stat.match) begin
                        o_cmd.found = 1'b1;
                        n_state     = S_FIN;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end
                end else if (i_stat.ge) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/slif_dpath.sv -----
// ----------------------------------------------------------------------------
// slif_dpath
// Entry memory, scan pointer, count and output register of the sorted list.
// ----------------------------------------------------------------------------
module slif_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_action,
    input  logic signed [31:0]    i_value,
    input  logic                  i_ready,
    input  slif_pkg::t_cmd        i_cmd,
    output slif_pkg::t_stat       o_stat,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [slif_pkg::POS_W-1:0] o_position,
    output logic [slif_pkg::CNT_W-1:0] o_entry_count
);
    import slif_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_val;
    logic               r_act;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_count;
    logic [1:0]         r_pend_status;
    logic [CW-1:0]      r_pend_pos;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [POS_W-1:0]   r_out_pos;
    logic [CNT_W-1:0]   r_out_count;

    logic [CW-1:0]      rd_ptr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;
    logic [CW+POS_W-1:0] pos_ext;
    logic [CW+CNT_W-1:0] cnt_ext;

    // Insert scans downward from the top, find scans upward from zero
    assign rd_ptr  = r_act ? r_ptr : r_ptr - CW'(1);
    assign rd_addr = rd_ptr[AW-1:0];
    assign wr_addr = r_ptr[AW-1:0];
    assign wr_en   = i_cmd.shift | i_cmd.put;
    assign wr_data = i_cmd.shift ? r_rdata : r_val;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Latch input word and advance the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
            r_act <= i_action;
            r_ptr <= (i_action == ACT_FIND) ? '0 : r_count;
        end else if (i_cmd.shift) begin
            r_ptr <= r_ptr - CW'(1);
        end else if (i_cmd.adv) begin
            r_ptr <= r_ptr + CW'(1);
        end
    end

    // Hold the result of the current word until it is emitted
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pend_status <= (i_action == ACT_FIND) ? ST_NOTFOUND : ST_DONE;
            r_pend_pos    <= '0;
        end else if (i_cmd.full) begin
            r_pend_status <= ST_FULL;
            r_pend_pos    <= '0;
        end else if (i_cmd.found || i_cmd.put) begin
            r_pend_status <= ST_DONE;
            r_pend_pos    <= r_ptr;
        end
    end

    // Count stored entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.put) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Wrap position and count to their field widths
    assign pos_ext = (CW + POS_W)'(r_pend_pos);
    assign cnt_ext = (CW + CNT_W)'(r_count);

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_pend_status;
            r_out_pos    <= pos_ext[POS_W-1:0];
            r_out_count  <= cnt_ext[CNT_W-1:0];
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.act_find = (r_act == ACT_FIND);
        o_stat.full     = (r_count >= CW'(CAPACITY));
        o_stat.ptr_zero = (r_ptr == '0);
        o_stat.ptr_end  = (r_ptr == r_count);
        o_stat.ge       = (r_rdata >= r_val);
        o_stat.match    = (r_rdata == r_val);
        o_stat.out_free = !r_out_valid || i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

endmodule

// ----- hw/rtl/sorted_list_insert_find.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_find
// Bounded list of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one word: i_action (0 insert,
// 1 find) and i_value. Output channel (o_valid/i_ready) returns one word per
// input: o_status (0 done or found, 1 not found, 2 full and dropped),
// o_position and o_entry_count, the count after the word.
// Words are handled one at a time. The entries sit in a single-port-read
// memory with a registered read, and the scan reads one entry at a time:
//   insert scans down from the count, shifting up each entry not smaller
//   than the value, and writes the value into the freed place
//   find scans up from index zero until a match or the count is reached
//   insert into a full list is dropped without a scan
// A new word is taken once the previous result sits in the output register,
// even while that result still waits; if the receiver stalls, the next
// result waits in the datapath's pending registers and no further word is taken.
// Reset empties the list at once (count to zero); stale memory contents are
// never read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_insert_find #(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic signed [31:0]         i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [slif_pkg::POS_W-1:0] o_position,
    output logic [slif_pkg::CNT_W-1:0] o_entry_count
);
    import slif_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    slif_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Memory, pointer and result registers
    slif_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_ready       (i_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

endmodule
